@@ rtl/fwd_pkg.sv @@
package fwd_pkg;

    // Width of one stored handle.
    localparam int DATA_W = 32;

    // Operation codes carried on the mode field.
    localparam logic [1:0] MODE_ENQ = 2'd0;
    localparam logic [1:0] MODE_DEQ = 2'd1;
    localparam logic [1:0] MODE_DEL = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // Controller states: waiting for a word, or executing the captured one.
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Per-cell control from the controller.
    typedef struct packed {
        logic capture;   // compare the stored handle with the incoming key
        logic occupied;  // this slot lies below the current length
        logic load;      // store the new handle (enqueue at the tail)
        logic shift;     // take the neighbor's handle (close a gap)
    } t_cell_ctl;

endpackage

@@ rtl/fwd_cell.sv @@
module fwd_cell
    import fwd_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [DATA_W-1:0] i_key,
    input  logic [DATA_W-1:0] i_load_data,
    input  logic [DATA_W-1:0] i_next_data,
    output logic [DATA_W-1:0] o_data,
    output logic              o_match
);

    logic [DATA_W-1:0] r_data;
    logic              r_match;

    // Stored handle: a new tail entry, or the neighbor's handle on a shift.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data <= i_load_data;
        end else if (i_ctl.shift) begin
            r_data <= i_next_data;
        end
    end

    // Match flag is taken when a word is accepted and held for the execute step.
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_match <= i_ctl.occupied && (r_data == i_key);
        end
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

@@ rtl/fifo_with_delete_by_value_unit.sv @@
// Ordered queue of nonzero 32-bit handles with removal by value.
// Input channel (i_in_valid / o_in_ready) carries one word: i_mode selects
// enqueue, dequeue or delete of the first entry equal to i_item_value.
// Output channel (o_out_valid / i_out_ready) returns one word per input word:
// o_status, o_item_out (the removed head on a good dequeue, else zero) and
// o_length, the number of entries held afterwards.
// Storage is a row of DEPTH cells; each compares its handle with the key in
// parallel and, on removal, takes its neighbor's handle.
// On accept, the cells register their per-cell match flags; in the execute
// step the first match is resolved through a log2(DEPTH) prefix network, all
// cells update and the result is registered. A new word is accepted only
// once the execute step of the last word has finished.
// The result sits in an output register, so a new word is accepted while it
// waits. If the receiver stalls, the next word is held in the execute step
// until the output register frees up.
// Reset (synchronous, active low) empties the queue; no clearing pass runs.
module fifo_with_delete_by_value_unit
    import fwd_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_mode,
    input  logic [DATA_W-1:0] i_item_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_status,
    output logic [DATA_W-1:0] o_item_out,
    output logic [4:0]        o_length
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int LOGD = $clog2(DEPTH);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [1:0]        r_mode;
    logic [DATA_W-1:0] r_value;
    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_status, n_status;
    logic [DATA_W-1:0] r_item_out, n_item_out;
    logic [4:0]        r_length, n_length;

    logic              in_acc;
    logic              go;
    logic              do_enq, do_deq, do_del;
    logic [DEPTH-1:0]  match_vec;
    logic [DEPTH-1:0]  prefix;
    logic [DATA_W-1:0] cell_data [DEPTH];
    t_cell_ctl         cell_ctl  [DEPTH];

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign go         = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    // First-match mask: every cell at or beyond the first match shifts.
    always_comb begin
        prefix = match_vec;
        for (int k = 0; k < LOGD; k++) begin
            prefix = prefix | (prefix << (1 << k));
        end
    end

    // Row of storage cells.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] next_data;

        if (g == DEPTH - 1) begin : g_last
            assign next_data = r_value;
        end else begin : g_mid
            assign next_data = cell_data[g+1];
        end

        assign cell_ctl[g].capture  = in_acc;
        assign cell_ctl[g].occupied = (r_count > CW'(g));
        assign cell_ctl[g].load     = do_enq && (r_count == CW'(g));
        assign cell_ctl[g].shift    = do_deq || (do_del && prefix[g]);

        fwd_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl[g]),
            .i_key       (i_item_value),
            .i_load_data (r_value),
            .i_next_data (next_data),
            .o_data      (cell_data[g]),
            .o_match     (match_vec[g])
        );
    end

    // Captured operation.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode  <= i_mode;
            r_value <= i_item_value;
        end
    end

    // Control and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_item_out <= n_item_out;
        r_length   <= n_length;
    end

    // Next state, operation decode and result.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_item_out  = r_item_out;
        n_length    = r_length;
        do_enq      = 1'b0;
        do_deq      = 1'b0;
        do_del      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (go) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_item_out  = '0;
                    n_status    = ST_EMPTY;
                    case (r_mode)
                        MODE_ENQ: begin
                            if (r_value == '0) begin
                                n_status = ST_ZERO;
                            end else if (r_count == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status = ST_OK;
                                do_enq   = 1'b1;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        MODE_DEQ: begin
                            if (r_count != '0) begin
                                n_status   = ST_OK;
                                n_item_out = cell_data[0];
                                do_deq     = 1'b1;
                                n_count    = r_count - CW'(1);
                            end
                        end
                        MODE_DEL: begin
                            if (r_value == '0) begin
                                n_status = ST_ZERO;
                            end else if (prefix[DEPTH-1]) begin
                                n_status = ST_OK;
                                do_del   = 1'b1;
                                n_count  = r_count - CW'(1);
                            end
                        end
                        default: begin
                            n_status = ST_EMPTY;
                        end
                    endcase
                    n_length = 5'(n_count);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_item_out  = r_item_out;
    assign o_length    = r_length;

    // The length never goes past the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue length exceeds the number of cells");

    // Accepting a word alone never changes the stored length.
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> (r_count == $past(r_count)))
        else $error("length changed outside the execute step");

    // A result with an error status never returns a handle.
    a_item_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != ST_OK)) |-> (r_item_out == '0))
        else $error("handle returned with an error status");

    // A returned handle is never zero.
    a_item_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && do_deq) |-> (cell_data[0] != '0))
        else $error("zero handle found at the queue head");

endmodule

@@ tb/sv/fifo_with_delete_by_value_unit_chk.sv @@
`timescale 1ns / 100ps

// Watches both channels of the queue unit, keeps its own copy of the queue,
// predicts one result per accepted word and compares results in order.
module fifo_with_delete_by_value_unit_chk
    import fwd_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [1:0]        i_mode,
    input  logic [DATA_W-1:0] i_item_value,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [1:0]        i_status,
    input  logic [DATA_W-1:0] i_item_out,
    input  logic [4:0]        i_length,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_words,
    output int                o_checked,
    output int                o_full_rejects,
    output int                o_inner_deletes,
    output int                o_peak_length
);

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] item;
        logic [4:0]        length;
    } t_queue_result;

    // Shadow of the queue contents, head first.
    logic [DATA_W-1:0] held_handles[$];
    t_queue_result     expected_results[$];
    t_queue_result     want;

    int fail_total    = 0;
    int words_seen    = 0;
    int results_seen  = 0;
    int full_total    = 0;
    int inner_total   = 0;
    int peak_len      = 0;

    // One line per mismatch, and one more failure on the count.
    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] exp_val);
        $display("result %0d: %s is %h, expected %h", results_seen, what, got, exp_val);
        fail_total++;
    endtask

    // Applies one word to the shadow queue and returns the result it gives.
    function automatic t_queue_result apply_word(input logic [1:0] op,
                                                 input logic [DATA_W-1:0] handle);
        t_queue_result res;
        int            hit;
        res.status = ST_OK;
        res.item   = '0;
        hit        = -1;
        case (op)
            MODE_ENQ: begin
                // A zero handle is rejected before the queue is checked for room.
                if (handle == '0) begin
                    res.status = ST_ZERO;
                end else if (held_handles.size() >= DEPTH) begin
                    res.status = ST_FULL;
                    full_total++;
                end else begin
                    held_handles.push_back(handle);
                end
            end
            MODE_DEQ: begin
                if (held_handles.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.item = held_handles.pop_front();
                end
            end
            MODE_DEL: begin
                if (handle == '0) begin
                    res.status = ST_ZERO;
                end else begin
                    // Only the copy nearest the head goes away.
                    foreach (held_handles[i]) begin
                        if (hit < 0 && held_handles[i] == handle) hit = i;
                    end
                    if (hit < 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        held_handles.delete(hit);
                        if (hit > 0) inner_total++;
                    end
                end
            end
            default: begin
                res.status = ST_EMPTY;
            end
        endcase
        res.length = 5'(held_handles.size());
        if (held_handles.size() > peak_len) peak_len = held_handles.size();
        return res;
    endfunction

    // Predict on every accepted word, compare on every accepted result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_handles.delete();
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(apply_word(i_mode, i_item_value));
                words_seen++;
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word, status", DATA_W'(i_status), '0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", DATA_W'(i_status), DATA_W'(want.status));
                    if (i_item_out !== want.item)
                        report_mismatch("item_out", i_item_out, want.item);
                    if (i_length !== want.length)
                        report_mismatch("length", DATA_W'(i_length), DATA_W'(want.length));
                end
                results_seen++;
            end
        end
        o_fail_count    <= fail_total;
        o_pending       <= expected_results.size();
        o_words         <= words_seen;
        o_checked       <= results_seen;
        o_full_rejects  <= full_total;
        o_inner_deletes <= inner_total;
        o_peak_length   <= peak_len;
    end

endmodule

@@ tb/sv/fifo_with_delete_by_value_unit_tb.sv @@
`timescale 1ns / 100ps

module fifo_with_delete_by_value_unit_tb;
    import fwd_pkg::*;

    localparam int         QUEUE_DEPTH  = 16;
    localparam int         PHASES       = 10;
    localparam int         PHASE_WORDS  = 115;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic [1:0]        mode         = MODE_ENQ;
    logic [DATA_W-1:0] item_value   = '0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic [1:0]        status;
    logic [DATA_W-1:0] item_out;
    logic [4:0]        length;

    // Set for phases that run both sides without gaps.
    logic no_idle   = 1'b0;
    int   stall_left = 0;
    int   ready_draw;

    int fail_count;
    int pending;
    int words;
    int checked;
    int full_rejects;
    int inner_deletes;
    int peak_length;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    fifo_with_delete_by_value_unit #(
        .DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_mode       (mode),
        .i_item_value (item_value),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_status     (status),
        .o_item_out   (item_out),
        .o_length     (length)
    );

    fifo_with_delete_by_value_unit_chk #(
        .DEPTH(QUEUE_DEPTH)
    ) i_chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_mode          (mode),
        .i_item_value    (item_value),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_status        (status),
        .i_item_out      (item_out),
        .i_length        (length),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words         (words),
        .o_checked       (checked),
        .o_full_rejects  (full_rejects),
        .o_inner_deletes (inner_deletes),
        .o_peak_length   (peak_length)
    );

    // Result side: after each accepted result, hold ready low for a drawn stall.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else if (out_ready && out_valid) begin
            ready_draw = no_idle ? 0 : $urandom_range(0, 6);
            if (ready_draw == 0) begin
                out_ready <= 1'b1;
            end else begin
                out_ready  <= 1'b0;
                stall_left <= ready_draw;
            end
        end else if (!out_ready) begin
            if (stall_left <= 1) out_ready <= 1'b1;
            if (stall_left > 0) stall_left <= stall_left - 1;
        end
    end

    // Presents one word after a drawn gap and returns at the edge that takes it.
    task automatic send_word(input logic [1:0] op, input logic [DATA_W-1:0] handle);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= op;
        item_value <= handle;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Mostly a few small handles so that deletes hit and duplicates occur.
    function automatic logic [DATA_W-1:0] pick_handle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) begin
            case ($urandom_range(0, 3))
                0: return 32'h0000_0001;
                1: return 32'hFFFF_FFFF;
                2: return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        if (r < 75) return DATA_W'($urandom_range(1, 12));
        return $urandom();
    endfunction

    // Filling phases lean on enqueue, draining phases on dequeue and delete.
    function automatic logic [1:0] pick_mode(input bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (r >= 96) return MODE_UNUSED;
        if (r < (filling ? 60 : 22)) return MODE_ENQ;
        if (r < (filling ? 78 : 58)) return MODE_DEQ;
        return MODE_DEL;
    endfunction

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Error cases on an empty queue.
        send_word(MODE_DEQ, 32'h1234_5678);
        send_word(MODE_DEL, 32'h0000_0005);
        send_word(MODE_DEL, 32'h0000_0000);
        send_word(MODE_ENQ, 32'h0000_0000);
        send_word(MODE_UNUSED, 32'hFFFF_FFFF);

        // Fill to the brim with extreme handles and one duplicate.
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            send_word(MODE_ENQ, (k == 0) ? 32'hFFFF_FFFF :
                                (k == 1 || k == 4) ? 32'h0000_0001 :
                                (k == 2) ? 32'h8000_0000 :
                                (k == 3) ? 32'h7FFF_FFFF :
                                32'h0001_0001 * k);
        end

        // Full queue, then removal at the head, the middle and the tail.
        send_word(MODE_ENQ, 32'h0000_0005);
        send_word(MODE_ENQ, 32'h0000_0000);
        send_word(MODE_DEL, 32'h0000_0001);
        send_word(MODE_DEL, 32'hDEAD_BEEF);
        send_word(MODE_DEL, 32'h7FFF_FFFF);
        send_word(MODE_DEQ, 32'h0000_0000);
        send_word(MODE_DEL, 32'h0001_0001 * (QUEUE_DEPTH - 1));

        // Random phases that alternately fill and drain the queue.
        for (int p = 0; p < PHASES; p++) begin
            no_idle <= (p % 3 == 2);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_word(pick_mode(p % 2 == 0), pick_handle());
            end
        end
        in_valid <= 1'b0;

        // Let the last results drain before judging.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d words and checked %0d results; peak length %0d.",
                 words, checked, peak_length);
        $display("Enqueues refused when full: %0d; deletes behind the head: %0d.",
                 full_rejects, inner_deletes);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #(2_000_000);
        $display("status: fail");
        $finish;
    end

endmodule

@@ fifo_with_delete_by_value_unit.f @@
rtl/fwd_pkg.sv
rtl/fwd_cell.sv
rtl/fifo_with_delete_by_value_unit.sv
tb/sv/fifo_with_delete_by_value_unit_chk.sv
tb/sv/fifo_with_delete_by_value_unit_tb.sv
